### hdl/ctc_pkg.sv
// Package for the calendar time counter: payload structs, action codes,
// counter limits, reset time and small calendar helper functions. No dependencies.

package ctc_pkg;

  // Action codes carried in the input payload
  localparam logic [2:0] ACT_USEC = 3'd0;
  localparam logic [2:0] ACT_MSEC = 3'd1;
  localparam logic [2:0] ACT_ADD  = 3'd2;
  localparam logic [2:0] ACT_SEC  = 3'd3;
  localparam logic [2:0] ACT_MIN  = 3'd4;
  localparam logic [2:0] ACT_HOUR = 3'd5;
  localparam logic [2:0] ACT_DAY  = 3'd6;

  // Counter limits
  localparam logic [9:0]  SUB_MAX    = 10'd999;
  localparam logic [10:0] SUB_MOD    = 11'd1000;
  localparam logic [5:0]  SIXTY_LAST = 6'd59;
  localparam logic [4:0]  HOUR_LAST  = 5'd23;
  localparam logic [3:0]  MONTH_LAST = 4'd12;
  localparam logic [6:0]  YEAR_LAST  = 7'd99;
  localparam logic [6:0]  CENT_LAST  = 7'd99;
  localparam logic [3:0]  MILL_LAST  = 4'd9;

  // Reset time
  localparam logic [9:0] RST_USEC  = 10'd0;
  localparam logic [9:0] RST_MSEC  = 10'd0;
  localparam logic [5:0] RST_SEC   = 6'd30;
  localparam logic [5:0] RST_MIN   = 6'd9;
  localparam logic [4:0] RST_HOUR  = 5'd8;
  localparam logic [4:0] RST_DAY   = 5'd31;
  localparam logic [3:0] RST_MONTH = 4'd7;
  localparam logic [6:0] RST_YEAR  = 7'd17;
  localparam logic [6:0] RST_CENT  = 7'd20;
  localparam logic [3:0] RST_MILL  = 4'd0;

  typedef struct packed {
    logic [2:0] action;
    logic [9:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [9:0] usec_out;
    logic [9:0] msec_out;
    logic [5:0] sec_out;
    logic [5:0] min_out;
    logic [4:0] hour_out;
    logic [4:0] day_out;
    logic [3:0] month_out;
    logic [6:0] year_out;
    logic [6:0] century_out;
    logic [3:0] millennium_out;
  } out_item_t;

  // Last day of the given month
  function automatic logic [4:0] month_last_day(input logic [3:0] month, input logic leap);
    logic [4:0] last;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: last = 5'd30;
      4'd2:                    last = leap ? 5'd29 : 5'd28;
      default:                 last = 5'd31;
    endcase
    return last;
  endfunction

  // True for 0, 10, 20 ... 90
  function automatic logic is_decade(input logic [6:0] v);
    logic hit;
    case (v) inside
      7'd0, 7'd10, 7'd20, 7'd30, 7'd40,
      7'd50, 7'd60, 7'd70, 7'd80, 7'd90: hit = 1'b1;
      default:                           hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

### hdl/calendar_time_counter_top.sv
// Calendar time counter top level: time registers, carry ripple and output handshake.
// Depends on ctc_pkg.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------
//  in      | in_valid / in_ready    | in_data  (in_item_t: action, amount)
//  out     | out_valid / out_ready  | out_data (out_item_t: full time)
//
// One transfer in gives one transfer out, offered in the cycle after it. The
// whole carry ripple from microseconds up to the millennium is combinational,
// so an item can be taken every cycle while the out side drains; the time
// registers double as the result register. in_ready is high whenever the result
// slot is empty or being drained in the same cycle, so a stalled out side holds
// the input back. Reset (rst, synchronous) loads 08:09:30.000000, day 31,
// month 7, year 17, century 20, millennium 0, and empties the result slot.

module calendar_time_counter_top
  import ctc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Time registers
  logic [9:0] usec_count, usec_next;
  logic [9:0] msec_count, msec_next;
  logic [5:0] sec_count, sec_next;
  logic [5:0] min_count, min_next;
  logic [4:0] hour_count, hour_next;
  logic [4:0] day_count, day_next;
  logic [3:0] month_count, month_next;
  logic [6:0] year_count, year_next;
  logic [6:0] century_count, century_next;
  logic [3:0] millennium_count, millennium_next;

  logic       in_xfer;

  // carry ripple signals
  logic       usec_wrap;
  logic       msec_inc, msec_wrap;
  logic [9:0] amt_sat;
  logic [10:0] add_sum;
  logic       add_carry;
  logic       sec_inc, sec_wrap;
  logic       min_inc, min_wrap;
  logic       hour_inc, hour_wrap;
  logic       day_inc, day_wrap;
  logic       leap;
  logic [4:0] day_last;
  logic       month_wrap;
  logic       year_wrap;
  logic [6:0] century_bumped;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Leap rule: year 00 looks at the century (full year divisible by 400)
  assign leap     = (year_count == 7'd0) ? (century_count[1:0] == 2'b00)
                                         : (year_count[1:0] == 2'b00);
  assign day_last = month_last_day(month_count, leap);

  // Add path saturates amount and carries at most one second
  assign amt_sat   = (in_data.amount > SUB_MAX) ? SUB_MAX : in_data.amount;
  assign add_sum   = {1'b0, msec_count} + {1'b0, amt_sat};
  assign add_carry = (in_data.action == ACT_ADD) && (add_sum >= SUB_MOD);

  // Ripple: each level up to day steps on its own action or on the carry from below; month and above only on the carry
  assign usec_wrap  = (in_data.action == ACT_USEC) && (usec_count >= SUB_MAX);
  assign msec_inc   = (in_data.action == ACT_MSEC) || usec_wrap;
  assign msec_wrap  = msec_inc && (msec_count >= SUB_MAX);
  assign sec_inc    = (in_data.action == ACT_SEC) || msec_wrap || add_carry;
  assign sec_wrap   = sec_inc && (sec_count >= SIXTY_LAST);
  assign min_inc    = (in_data.action == ACT_MIN) || sec_wrap;
  assign min_wrap   = min_inc && (min_count >= SIXTY_LAST);
  assign hour_inc   = (in_data.action == ACT_HOUR) || min_wrap;
  assign hour_wrap  = hour_inc && (hour_count >= HOUR_LAST);
  assign day_inc    = (in_data.action == ACT_DAY) || hour_wrap;
  assign day_wrap   = day_inc && (day_count >= day_last);
  assign month_wrap = day_wrap && (month_count >= MONTH_LAST);
  assign year_wrap  = month_wrap && (year_count >= YEAR_LAST);

  assign century_bumped = (century_count >= CENT_LAST) ? 7'd0 : century_count + 7'd1;

  always_comb begin
    usec_next = usec_count;
    if (in_data.action == ACT_USEC) begin
      usec_next = usec_wrap ? 10'd0 : usec_count + 10'd1;
    end

    msec_next = msec_count;
    if (in_data.action == ACT_ADD) begin
      msec_next = add_carry ? 10'(add_sum - SUB_MOD) : add_sum[9:0];
    end else if (msec_inc) begin
      msec_next = msec_wrap ? 10'd0 : msec_count + 10'd1;
    end

    sec_next   = sec_inc  ? (sec_wrap  ? 6'd0 : sec_count + 6'd1)  : sec_count;
    min_next   = min_inc  ? (min_wrap  ? 6'd0 : min_count + 6'd1)  : min_count;
    hour_next  = hour_inc ? (hour_wrap ? 5'd0 : hour_count + 5'd1) : hour_count;
    day_next   = day_inc  ? (day_wrap  ? 5'd1 : day_count + 5'd1)  : day_count;
    month_next = day_wrap ? (month_wrap ? 4'd1 : month_count + 4'd1) : month_count;
    year_next  = month_wrap ? (year_wrap ? 7'd0 : year_count + 7'd1) : year_count;

    century_next    = year_wrap ? century_bumped : century_count;
    millennium_next = millennium_count;
    // millennium steps whenever the bumped century lands on a multiple of ten
    if (year_wrap && is_decade(century_bumped)) begin
      millennium_next = (millennium_count >= MILL_LAST) ? 4'd0 : millennium_count + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      usec_count       <= RST_USEC;
      msec_count       <= RST_MSEC;
      sec_count        <= RST_SEC;
      min_count        <= RST_MIN;
      hour_count       <= RST_HOUR;
      day_count        <= RST_DAY;
      month_count      <= RST_MONTH;
      year_count       <= RST_YEAR;
      century_count    <= RST_CENT;
      millennium_count <= RST_MILL;
      out_valid        <= 1'b0;
    end else begin
      if (in_xfer) begin
        usec_count       <= usec_next;
        msec_count       <= msec_next;
        sec_count        <= sec_next;
        min_count        <= min_next;
        hour_count       <= hour_next;
        day_count        <= day_next;
        month_count      <= month_next;
        year_count       <= year_next;
        century_count    <= century_next;
        millennium_count <= millennium_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Time registers are frozen while a result waits, so they drive the output
  assign out_data.usec_out       = usec_count;
  assign out_data.msec_out       = msec_count;
  assign out_data.sec_out        = sec_count;
  assign out_data.min_out        = min_count;
  assign out_data.hour_out       = hour_count;
  assign out_data.day_out        = day_count;
  assign out_data.month_out      = month_count;
  assign out_data.year_out       = year_count;
  assign out_data.century_out    = century_count;
  assign out_data.millennium_out = millennium_count;

endmodule
